// ===== hw/rtl/geochd_pkg.sv =====
package geochd_pkg;

    // defaults for the top-level parameters
    localparam int CORDIC_STAGES_DEF   = 24;
    localparam int ANGLE_FRAC_BITS_DEF = 16;

    // field widths
    localparam int LON_W    = 25;
    localparam int LAT_W    = 24;
    localparam int ALT_W    = 27;
    localparam int RADIUS_W = 24;
    localparam int DIST_W   = 27;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371000;
    localparam logic [DIST_W-1:0]   DIST_MAX     = 27'd134217727;

    // binary angle and cordic datapath
    localparam int BAM_W     = 32;
    localparam int ANG_MAG_W = 25;
    localparam int ANGLE_LAT = 4;
    localparam int CORD_W    = 34;
    localparam int TAB_LEN   = 32;
    localparam logic signed [CORD_W-1:0] CORDIC_START = 34'sd652032874;

    // coordinate and distance datapath
    localparam int RAD_W    = 28;
    localparam int COORD_W  = 32;
    localparam int DIFF_W   = 31;
    localparam int SUM_W    = 62;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int POST_LAT = 4;

    // arctangent of 2^-i, full turn = 2^32
    localparam logic [BAM_W-1:0] ATAN_TAB [0:TAB_LEN-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

// ===== hw/rtl/geochd_angle.sv =====
module geochd_angle #(
    parameter int ANGLE_FRAC_BITS = geochd_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int IN_W            = geochd_pkg::LON_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic signed [IN_W-1:0]         angle,
    output logic                           out_valid,
    output logic [geochd_pkg::BAM_W-1:0]   bam
);

    localparam int MAG_W = geochd_pkg::ANG_MAG_W;
    localparam int SH    = geochd_pkg::BAM_W - ANGLE_FRAC_BITS - 3;
    localparam int K1    = MAG_W + 6;
    localparam logic [63:0] M1 = ((64'd1 << K1) + 64'd44) / 64'd45;
    localparam int Q1_W  = MAG_W - 5;
    localparam int VW    = 6 + SH;
    localparam int K2    = VW + 6;
    localparam logic [63:0] M2 = ((64'd1 << K2) + 64'd44) / 64'd45;

    logic signed [MAG_W-1:0] ang_ext;
    logic [MAG_W-1:0]        mag_next;
    logic [Q1_W-1:0]         q1_next;
    logic [5:0]              r1_next;
    logic [VW-1:0]           v_next;
    logic [63:0]             full_sum;
    logic [31:0]             a_pos;

    logic [3:0]              vld_reg;
    logic [2:0]              neg_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic [63:0]             prod1_reg;
    logic [Q1_W-1:0]         q1_reg [0:1];
    logic [VW-1:0]           v_reg;
    logic [63:0]             prod2_reg;
    logic [31:0]             bam_reg;

    // magnitude, then divide by 360 as divide by 8 and two reciprocal steps by 45
    assign ang_ext  = MAG_W'(angle);
    assign mag_next = ang_ext[MAG_W-1] ? MAG_W'(-ang_ext) : MAG_W'(ang_ext);
    assign q1_next  = prod1_reg[K1 +: Q1_W];
    assign r1_next  = 6'(mag_reg - MAG_W'(MAG_W'(q1_next) * MAG_W'(45)));
    assign v_next   = (VW'(r1_next) << SH) + VW'(22);
    assign full_sum = (64'(q1_reg[1]) << SH) + (prod2_reg >> K2);
    assign a_pos    = full_sum[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        neg_reg   <= {neg_reg[1:0], ang_ext[MAG_W-1]};
        prod1_reg <= 64'(mag_next) * M1;
        q1_reg[0] <= q1_next;
        v_reg     <= v_next;
        q1_reg[1] <= q1_reg[0];
        prod2_reg <= 64'(v_reg) * M2;
        bam_reg   <= neg_reg[2] ? (32'd0 - a_pos) : a_pos;
    end

    assign out_valid = vld_reg[3];
    assign bam       = bam_reg;

endmodule

// ===== hw/rtl/geochd_cordic.sv =====
module geochd_cordic #(
    parameter int STAGES = geochd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic [geochd_pkg::BAM_W-1:0]           bam,
    output logic                                   out_valid,
    output logic signed [geochd_pkg::CORD_W-1:0]   cos_q30,
    output logic signed [geochd_pkg::CORD_W-1:0]   sin_q30
);

    localparam int W = geochd_pkg::CORD_W;

    logic                 flip_in;
    logic [31:0]          folded;
    logic signed [W-1:0]  x_reg [0:STAGES];
    logic signed [W-1:0]  y_reg [0:STAGES];
    logic signed [W-1:0]  z_reg [0:STAGES];
    logic                 flip_reg [0:STAGES];
    logic                 vld_reg [0:STAGES+1];
    logic signed [W-1:0]  cos_reg;
    logic signed [W-1:0]  sin_reg;

    // quadrants 1 and 2 are rotated by a half turn and negated at the end
    assign flip_in = (bam[31:30] == 2'b01) || (bam[31:30] == 2'b10);
    assign folded  = flip_in ? (bam + 32'h80000000) : bam;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STAGES + 1; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= STAGES + 1; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= geochd_pkg::CORDIC_START;
        y_reg[0]    <= '0;
        z_reg[0]    <= W'($signed(folded));
        flip_reg[0] <= flip_in;
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [W-1:0] atan_s;
        logic signed [W-1:0] x_next;
        logic signed [W-1:0] y_next;
        logic signed [W-1:0] z_next;

        assign atan_s = $signed({{(W-geochd_pkg::BAM_W){1'b0}}, geochd_pkg::ATAN_TAB[i]});

        always_comb
        begin
            if (!z_reg[i][W-1])
            begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - atan_s;
            end
            else
            begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + atan_s;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1]    <= x_next;
            y_reg[i+1]    <= y_next;
            z_reg[i+1]    <= z_next;
            flip_reg[i+1] <= flip_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= flip_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
        sin_reg <= flip_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES];
    end

    assign out_valid = vld_reg[STAGES+1];
    assign cos_q30   = cos_reg;
    assign sin_q30   = sin_reg;

endmodule

// ===== hw/rtl/geochd_sqrt.sv =====
module geochd_sqrt (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [geochd_pkg::SUM_W-1:0]       radicand,
    output logic                               out_valid,
    output logic [geochd_pkg::ROOT_W-1:0]      root
);

    localparam int N  = geochd_pkg::ROOT_W;
    localparam int SW = geochd_pkg::SUM_W;
    localparam int RW = N + 1;

    logic [SW-1:0] rad_in  [0:N];
    logic [RW-1:0] rem_in  [0:N];
    logic [N-1:0]  root_in [0:N];
    logic          vld_in  [0:N];

    logic [SW-1:0] rad_reg  [0:N-1];
    logic [RW-1:0] rem_reg  [0:N-1];
    logic [N-1:0]  root_reg [0:N-1];
    logic          vld_reg  [0:N-1];

    assign rad_in[0]  = radicand;
    assign rem_in[0]  = '0;
    assign root_in[0] = '0;
    assign vld_in[0]  = in_valid;

    // one result bit per stage, restoring digit recurrence
    for (genvar j = 0; j < N; j++)
    begin : g_digit
        logic [RW+1:0] t;
        logic [RW+1:0] trial;
        logic [RW-1:0] rem_next;
        logic [N-1:0]  root_next;

        assign t     = {rem_in[j], rad_in[j][SW-1 -: 2]};
        assign trial = {1'b0, root_in[j], 2'b01};

        always_comb
        begin
            if (t >= trial)
            begin
                rem_next  = RW'(t - trial);
                root_next = {root_in[j][N-2:0], 1'b1};
            end
            else
            begin
                rem_next  = RW'(t);
                root_next = {root_in[j][N-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= vld_in[j];
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[j]  <= rad_in[j] << 2;
            rem_reg[j]  <= rem_next;
            root_reg[j] <= root_next;
        end

        assign rad_in[j+1]  = rad_reg[j];
        assign rem_in[j+1]  = rem_reg[j];
        assign root_in[j+1] = root_reg[j];
        assign vld_in[j+1]  = vld_reg[j];
    end

    assign out_valid = vld_in[N];
    assign root      = root_in[N];

endmodule

// ===== hw/rtl/geodetic_chord_distance.sv =====
// throughput: one point pair per cycle, busy never rises
// the result passes through the angle divider, cordic, the product and square
// stages, the root recurrence and the output stage
// reset: rst_n clears all valid bits and loads radius_reg with 6371000
// done marks the result for exactly one cycle; the receiver cannot stall it
module geodetic_chord_distance #(
    parameter int CORDIC_STAGES   = geochd_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = geochd_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // item beat
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [geochd_pkg::LON_W-1:0]    first_longitude,
    input  logic signed [geochd_pkg::LAT_W-1:0]    first_latitude,
    input  logic signed [geochd_pkg::ALT_W-1:0]    first_altitude,
    input  logic signed [geochd_pkg::LON_W-1:0]    second_longitude,
    input  logic signed [geochd_pkg::LAT_W-1:0]    second_latitude,
    input  logic signed [geochd_pkg::ALT_W-1:0]    second_altitude,
    // result beat
    output logic                                   done,
    output logic [geochd_pkg::DIST_W-1:0]          distance_m,
    // radius register write
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [geochd_pkg::RADIUS_W-1:0]        cfg_data
);

    localparam int CW      = geochd_pkg::CORD_W;
    localparam int AW      = geochd_pkg::ALT_W;
    localparam int RW      = geochd_pkg::RAD_W;
    localparam int PW      = geochd_pkg::COORD_W;
    localparam int DW      = geochd_pkg::DIFF_W;
    localparam int SW      = geochd_pkg::SUM_W;
    localparam int ALT_DLY = geochd_pkg::ANGLE_LAT + CORDIC_STAGES + 2;
    localparam int LAT     = ALT_DLY + geochd_pkg::POST_LAT + geochd_pkg::ROOT_W + 1;

    logic accept;
    assign accept    = start && !busy;
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // radius register
    logic [geochd_pkg::RADIUS_W-1:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= geochd_pkg::RADIUS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radius_reg <= cfg_data;
        end
    end

    // four angles: lon1, lat1, lon2, lat2
    logic [geochd_pkg::BAM_W-1:0] bam [0:3];
    logic [3:0]                   bam_vld;
    logic [3:0]                   cord_vld;
    logic signed [CW-1:0]         cos_v [0:3];
    logic signed [CW-1:0]         sin_v [0:3];

    geochd_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .IN_W(geochd_pkg::LON_W)) u_ang_lon1 (
        .clk(clk), .rst_n(rst_n), .in_valid(accept), .angle(first_longitude),
        .out_valid(bam_vld[0]), .bam(bam[0])
    );
    geochd_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .IN_W(geochd_pkg::LAT_W)) u_ang_lat1 (
        .clk(clk), .rst_n(rst_n), .in_valid(accept), .angle(first_latitude),
        .out_valid(bam_vld[1]), .bam(bam[1])
    );
    geochd_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .IN_W(geochd_pkg::LON_W)) u_ang_lon2 (
        .clk(clk), .rst_n(rst_n), .in_valid(accept), .angle(second_longitude),
        .out_valid(bam_vld[2]), .bam(bam[2])
    );
    geochd_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .IN_W(geochd_pkg::LAT_W)) u_ang_lat2 (
        .clk(clk), .rst_n(rst_n), .in_valid(accept), .angle(second_latitude),
        .out_valid(bam_vld[3]), .bam(bam[3])
    );

    for (genvar g = 0; g < 4; g++)
    begin : g_cordic
        geochd_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
            .clk(clk), .rst_n(rst_n), .in_valid(bam_vld[g]), .bam(bam[g]),
            .out_valid(cord_vld[g]), .cos_q30(cos_v[g]), .sin_q30(sin_v[g])
        );
    end

    // altitudes ride alongside the angle and cordic stages
    logic signed [AW-1:0] alt1_dly_reg [0:ALT_DLY-1];
    logic signed [AW-1:0] alt2_dly_reg [0:ALT_DLY-1];

    always_ff @(posedge clk)
    begin
        alt1_dly_reg[0] <= first_altitude;
        alt2_dly_reg[0] <= second_altitude;
        for (int k = 1; k < ALT_DLY; k++)
        begin
            alt1_dly_reg[k] <= alt1_dly_reg[k-1];
            alt2_dly_reg[k] <= alt2_dly_reg[k-1];
        end
    end

    // stage p1: direction factors in q30 and radii
    logic signed [2*CW-1:0] fx1_next, fy1_next, fx2_next, fy2_next;
    logic signed [CW-1:0]   fx1_reg, fy1_reg, fz1_reg, fx2_reg, fy2_reg, fz2_reg;
    logic signed [RW-1:0]   r1_reg, r2_reg;
    logic signed [RW-1:0]   base_s;

    localparam logic signed [2*CW-1:0] HALF30 = (2*CW)'(1) << 29;

    assign fx1_next = cos_v[1] * cos_v[0] + HALF30;
    assign fy1_next = cos_v[1] * sin_v[0] + HALF30;
    assign fx2_next = cos_v[3] * cos_v[2] + HALF30;
    assign fy2_next = cos_v[3] * sin_v[2] + HALF30;
    assign base_s   = $signed({{(RW-geochd_pkg::RADIUS_W){1'b0}}, radius_reg});

    always_ff @(posedge clk)
    begin
        fx1_reg <= $signed(fx1_next[30 +: CW]);
        fy1_reg <= $signed(fy1_next[30 +: CW]);
        fz1_reg <= sin_v[1];
        fx2_reg <= $signed(fx2_next[30 +: CW]);
        fy2_reg <= $signed(fy2_next[30 +: CW]);
        fz2_reg <= sin_v[3];
        r1_reg  <= base_s + RW'(alt1_dly_reg[ALT_DLY-1]);
        r2_reg  <= base_s + RW'(alt2_dly_reg[ALT_DLY-1]);
    end

    // stage p2: cartesian coordinates in quarter metres
    localparam int PRW = RW + CW;
    localparam logic signed [PRW-1:0] HALF28 = PRW'(1) << 27;

    logic signed [PRW-1:0] cx1_next, cy1_next, cz1_next, cx2_next, cy2_next, cz2_next;
    logic signed [PW-1:0]  p1_reg [0:2];
    logic signed [PW-1:0]  p2_reg [0:2];

    assign cx1_next = PRW'(r1_reg) * PRW'(fx1_reg) + HALF28;
    assign cy1_next = PRW'(r1_reg) * PRW'(fy1_reg) + HALF28;
    assign cz1_next = PRW'(r1_reg) * PRW'(fz1_reg) + HALF28;
    assign cx2_next = PRW'(r2_reg) * PRW'(fx2_reg) + HALF28;
    assign cy2_next = PRW'(r2_reg) * PRW'(fy2_reg) + HALF28;
    assign cz2_next = PRW'(r2_reg) * PRW'(fz2_reg) + HALF28;

    always_ff @(posedge clk)
    begin
        p1_reg[0] <= $signed(cx1_next[28 +: PW]);
        p1_reg[1] <= $signed(cy1_next[28 +: PW]);
        p1_reg[2] <= $signed(cz1_next[28 +: PW]);
        p2_reg[0] <= $signed(cx2_next[28 +: PW]);
        p2_reg[1] <= $signed(cy2_next[28 +: PW]);
        p2_reg[2] <= $signed(cz2_next[28 +: PW]);
    end

    // stage p3: per-axis squared differences
    logic [2*DW-1:0] sq_reg [0:2];

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        logic signed [PW:0] diff;
        logic [DW-1:0]      mag;

        assign diff = (PW+1)'(p2_reg[a]) - (PW+1)'(p1_reg[a]);
        assign mag  = diff[PW] ? DW'(-diff) : DW'(diff);

        always_ff @(posedge clk)
        begin
            sq_reg[a] <= (2*DW)'(mag) * (2*DW)'(mag);
        end
    end

    // stage p4: sum of squares
    logic [2*DW+1:0] sum_next;
    logic [SW-1:0]   sum_reg;

    assign sum_next = (2*DW+2)'(sq_reg[0]) + (2*DW+2)'(sq_reg[1]) + (2*DW+2)'(sq_reg[2]);

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next[SW-1:0];
    end

    // valid bits through p1..p4
    logic [geochd_pkg::POST_LAT-1:0] pv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
        end
        else
        begin
            pv_reg <= {pv_reg[geochd_pkg::POST_LAT-2:0], cord_vld[0]};
        end
    end

    // root in quarter metres
    logic                          root_vld;
    logic [geochd_pkg::ROOT_W-1:0] root_q2;

    geochd_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n),
        .in_valid(pv_reg[geochd_pkg::POST_LAT-1]), .radicand(sum_reg),
        .out_valid(root_vld), .root(root_q2)
    );

    // round to metres and saturate
    logic [geochd_pkg::ROOT_W:0]   rounded;
    logic [geochd_pkg::ROOT_W-2:0] metres;
    logic                          done_reg;
    logic [geochd_pkg::DIST_W-1:0] dist_reg;

    assign rounded = (geochd_pkg::ROOT_W+1)'(root_q2) + (geochd_pkg::ROOT_W+1)'(2);
    assign metres  = rounded[geochd_pkg::ROOT_W:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= root_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (metres > (geochd_pkg::ROOT_W-1)'(geochd_pkg::DIST_MAX))
        begin
            dist_reg <= geochd_pkg::DIST_MAX;
        end
        else
        begin
            dist_reg <= metres[geochd_pkg::DIST_W-1:0];
        end
    end

    assign done       = done_reg;
    assign distance_m = dist_reg;

    // the four cordic lanes stay in lockstep
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (cord_vld == 4'b0000) || (cord_vld == 4'b1111))
        else $error("cordic lanes out of step");

    // every accepted beat yields a result after the fixed latency
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("result missing after accepted beat");

    // no result without a beat accepted the fixed latency earlier
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result without matching beat");

endmodule
